// File: hdl/hlp_pkg.sv
// shared types, character codes and byte classifiers for the header line parser
package hlp_pkg;

  localparam int DATA_W   = 8;
  localparam int HASH_W   = 32;
  localparam int LEN_W    = 12;
  localparam int BUCKET_W = 6;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADCHAR = 3'd1,
    ST_NONAME  = 3'd2,
    ST_NOVALUE = 3'd3,
    ST_NULL    = 3'd4,
    ST_LONG    = 3'd5
  } status_t;

  // parse phases
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_NAME  = 2'd1,
    PH_BLANK = 2'd2,
    PH_VALUE = 2'd3
  } phase_t;

  // one finished header line, before the bucket is worked out
  typedef struct packed {
    status_t             status;
    logic [HASH_W-1:0]   name_hash;
    logic [LEN_W-1:0]    name_length;
    logic [LEN_W-1:0]    value_offset;
    logic [LEN_W-1:0]    value_length;
  } result_t;

  // character codes
  localparam logic [DATA_W-1:0] CH_NUL    = 8'h00;
  localparam logic [DATA_W-1:0] CH_TAB    = 8'h09;
  localparam logic [DATA_W-1:0] CH_LF     = 8'h0A;
  localparam logic [DATA_W-1:0] CH_CR     = 8'h0D;
  localparam logic [DATA_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [DATA_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [DATA_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [DATA_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [DATA_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [DATA_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [DATA_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [DATA_W-1:0] CH_AT     = 8'h40;
  localparam logic [DATA_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [DATA_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [DATA_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [DATA_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [DATA_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [DATA_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [DATA_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [DATA_W-1:0] CH_DEL    = 8'h7F;
  localparam logic [DATA_W-1:0] CASE_OFFSET = 8'h20;

  // separators: colon to at-sign, brackets, quotes, comma, slashes, blanks
  function automatic logic is_separator(input logic [DATA_W-1:0] c);
    return (c >= CH_COLON && c <= CH_AT) ||
           c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA || c == CH_BSLASH ||
           c == CH_DQUOTE || c == CH_SLASH || c == CH_LBRACK || c == CH_RBRACK ||
           c == CH_LBRACE || c == CH_RBRACE || c == CH_SPACE || c == CH_TAB;
  endfunction

  // ascii upper to lower case
  function automatic logic [DATA_W-1:0] to_lower(input logic [DATA_W-1:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
  endfunction

endpackage

// File: hdl/hlp_byte_if.sv
// byte request channel of the header line parser
interface hlp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [hlp_pkg::DATA_W-1:0]  data_byte;
  logic                        line_start;

  modport source (output valid, output data_byte, output line_start, input ready);
  modport sink   (input valid, input data_byte, input line_start, output ready);
endinterface

// File: hdl/hlp_result_if.sv
// result channel of the header line parser
interface hlp_result_if;
  logic                          valid;
  logic                          ready;
  hlp_pkg::status_t              status;
  logic [hlp_pkg::HASH_W-1:0]    name_hash;
  logic [hlp_pkg::BUCKET_W-1:0]  bucket;
  logic [hlp_pkg::LEN_W-1:0]     name_length;
  logic [hlp_pkg::LEN_W-1:0]     value_offset;
  logic [hlp_pkg::LEN_W-1:0]     value_length;

  modport source (output valid, output status, output name_hash, output bucket,
                  output name_length, output value_offset, output value_length,
                  input ready);
  modport sink   (input valid, input status, input name_hash, input bucket,
                  input name_length, input value_offset, input value_length,
                  output ready);
endinterface

// File: hdl/hlp_parse.sv
// byte-wise header line parser: name check, name hash, blank skip, value scan
module hlp_parse #(
  parameter int MAX_LINE = 4096
) (
  input  logic             clk,
  input  logic             rst,
  hlp_byte_if.sink         bytes,
  output logic             res_valid,
  input  logic             res_ready,
  output hlp_pkg::result_t res
);

  localparam int POS_W = $clog2(MAX_LINE + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LINE);

  // parse state
  hlp_pkg::phase_t                phase, phase_next;
  logic [hlp_pkg::HASH_W-1:0]     hash, hash_next;
  logic [POS_W-1:0]               name_count, name_count_next;
  logic [POS_W-1:0]               value_start, value_start_next;
  logic [POS_W-1:0]               value_count, value_count_next;
  logic [POS_W-1:0]               line_pos, line_pos_next;
  logic                           cr_pending, cr_pending_next;

  // state as seen by this byte, after a line start clears it
  hlp_pkg::phase_t                ph_e;
  logic [hlp_pkg::HASH_W-1:0]     h_e;
  logic [POS_W-1:0]               n_e, vs_e, vc_e, pos_e;
  logic                           cr_e;

  // value state once blanks are done
  logic [POS_W-1:0]               vs_w, vc_w;
  logic                           cr_w;

  logic [hlp_pkg::DATA_W-1:0]     c;
  logic in_fire, is_colon, is_nul, is_blank, is_cr, is_lf, is_bad;
  logic too_long, to_value, line_end, emit;
  hlp_pkg::status_t               status;
  logic [POS_W-1:0]               out_vs, out_vc;

  assign c            = bytes.data_byte;
  assign bytes.ready  = !res_valid || res_ready;
  assign in_fire      = bytes.valid && bytes.ready;

  // effective state
  always_comb begin
    if (bytes.line_start) begin
      ph_e  = hlp_pkg::PH_NAME;
      h_e   = '0;
      n_e   = '0;
      vs_e  = '0;
      vc_e  = '0;
      pos_e = '0;
      cr_e  = 1'b0;
    end else begin
      ph_e  = phase;
      h_e   = hash;
      n_e   = name_count;
      vs_e  = value_start;
      vc_e  = value_count;
      pos_e = line_pos;
      cr_e  = cr_pending;
    end
  end

  // byte classes
  assign is_colon = (c == hlp_pkg::CH_COLON);
  assign is_nul   = (c == hlp_pkg::CH_NUL);
  assign is_blank = (c == hlp_pkg::CH_SPACE) || (c == hlp_pkg::CH_TAB);
  assign is_cr    = (c == hlp_pkg::CH_CR);
  assign is_lf    = (c == hlp_pkg::CH_LF);
  assign is_bad   = (c < hlp_pkg::CH_SPACE) || (c >= hlp_pkg::CH_DEL) ||
                    hlp_pkg::is_separator(c);

  assign too_long = (ph_e != hlp_pkg::PH_IDLE) && (pos_e == POS_LIMIT);
  assign to_value = (ph_e == hlp_pkg::PH_VALUE) ||
                    ((ph_e == hlp_pkg::PH_BLANK) && !is_blank);

  // first value byte opens a fresh value
  assign vs_w     = (ph_e == hlp_pkg::PH_BLANK) ? pos_e : vs_e;
  assign vc_w     = (ph_e == hlp_pkg::PH_BLANK) ? '0 : vc_e;
  assign cr_w     = (ph_e == hlp_pkg::PH_BLANK) ? 1'b0 : cr_e;
  assign line_end = is_lf && cr_w;

  // next phase
  always_comb begin
    phase_next = phase;
    if (in_fire) begin
      unique case (ph_e)
        hlp_pkg::PH_IDLE: begin
          phase_next = hlp_pkg::PH_IDLE;
        end
        hlp_pkg::PH_NAME: begin
          priority if (too_long) begin
            phase_next = hlp_pkg::PH_IDLE;
          end else if (is_colon) begin
            phase_next = (n_e == '0) ? hlp_pkg::PH_IDLE : hlp_pkg::PH_BLANK;
          end else if (is_nul || is_bad) begin
            phase_next = hlp_pkg::PH_IDLE;
          end else begin
            phase_next = hlp_pkg::PH_NAME;
          end
        end
        hlp_pkg::PH_BLANK, hlp_pkg::PH_VALUE: begin
          priority if (too_long) begin
            phase_next = hlp_pkg::PH_IDLE;
          end else if (!to_value) begin
            phase_next = hlp_pkg::PH_BLANK;
          end else if (is_nul || line_end) begin
            phase_next = hlp_pkg::PH_IDLE;
          end else begin
            phase_next = hlp_pkg::PH_VALUE;
          end
        end
      endcase
    end
  end

  // datapath and result decision
  always_comb begin
    hash_next        = h_e;
    name_count_next  = n_e;
    value_start_next = vs_e;
    value_count_next = vc_e;
    cr_pending_next  = cr_e;
    line_pos_next    = pos_e;
    emit             = 1'b0;
    status           = hlp_pkg::ST_OK;
    out_vs           = vs_e;
    out_vc           = vc_e;
    if (ph_e != hlp_pkg::PH_IDLE) begin
      if (too_long) begin
        emit   = 1'b1;
        status = hlp_pkg::ST_LONG;
      end else begin
        line_pos_next = pos_e + POS_W'(1);
        unique case (ph_e)
          hlp_pkg::PH_IDLE: begin
          end
          hlp_pkg::PH_NAME: begin
            priority if (is_colon) begin
              if (n_e == '0) begin
                emit   = 1'b1;
                status = hlp_pkg::ST_NONAME;
              end
            end else if (is_nul) begin
              emit   = 1'b1;
              status = hlp_pkg::ST_NULL;
            end else if (is_bad) begin
              emit   = 1'b1;
              status = hlp_pkg::ST_BADCHAR;
            end else begin
              hash_next = h_e ^ ((h_e << 5) + (h_e >> 2) +
                                 hlp_pkg::HASH_W'(hlp_pkg::to_lower(c)));
              name_count_next = n_e + POS_W'(1);
            end
          end
          hlp_pkg::PH_BLANK, hlp_pkg::PH_VALUE: begin
            if (to_value) begin
              value_start_next = vs_w;
              value_count_next = vc_w;
              cr_pending_next  = cr_w;
              out_vs           = vs_w;
              out_vc           = vc_w;
              priority if (is_nul) begin
                emit   = 1'b1;
                status = hlp_pkg::ST_NULL;
              end else if (line_end) begin
                emit            = 1'b1;
                status          = (vc_w == '0) ? hlp_pkg::ST_NOVALUE : hlp_pkg::ST_OK;
                cr_pending_next = 1'b0;
              end else begin
                // a held-back cr that was not followed by lf counts as value
                value_count_next = vc_w + POS_W'(cr_w) + POS_W'(!is_cr);
                cr_pending_next  = is_cr;
              end
            end
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= hlp_pkg::PH_IDLE;
      hash        <= '0;
      name_count  <= '0;
      value_start <= '0;
      value_count <= '0;
      line_pos    <= '0;
      cr_pending  <= 1'b0;
    end else if (in_fire) begin
      phase       <= phase_next;
      hash        <= hash_next;
      name_count  <= name_count_next;
      value_start <= value_start_next;
      value_count <= value_count_next;
      line_pos    <= line_pos_next;
      cr_pending  <= cr_pending_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      res.status       <= status;
      res.name_hash    <= h_e;
      res.name_length  <= hlp_pkg::LEN_W'(n_e);
      res.value_offset <= hlp_pkg::LEN_W'(out_vs);
      res.value_length <= hlp_pkg::LEN_W'(out_vc);
    end
  end

endmodule

// File: hdl/hlp_bucket.sv
// three-stage pipeline that reduces the name hash modulo the bucket count
module hlp_bucket #(
  parameter int BUCKETS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hlp_pkg::result_t in_res,
  hlp_result_if.source     results
);

  localparam int BW = $clog2(BUCKETS);
  localparam int RW = BW + 1;
  localparam int HW = hlp_pkg::HASH_W;
  // floor(2^32 / BUCKETS): quotient estimate is exact or one short
  localparam logic [HW-1:0] RECIP = HW'((64'd1 << HW) / BUCKETS);
  localparam logic [HW-1:0] DIVISOR = HW'(BUCKETS);
  localparam logic [RW-1:0] DIVISOR_R = RW'(BUCKETS);

  logic                 s1_valid, s2_valid, s3_valid;
  logic                 s1_ready, s2_ready, s3_ready;
  hlp_pkg::result_t     s1_res, s2_res;
  logic [2*HW-1:0]      s1_prod;
  logic [RW-1:0]        s2_rem;
  logic [HW-1:0]        quot, diff;

  // per-stage ready so bubbles close up
  assign s3_ready = !s3_valid || results.ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  assign quot = s1_prod[2*HW-1:HW];
  assign diff = s1_res.name_hash - HW'(quot * DIVISOR);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // quotient estimate by reciprocal multiply
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_res  <= in_res;
      s1_prod <= (2*HW)'(in_res.name_hash) * (2*HW)'(RECIP);
    end
  end

  // remainder, below twice the bucket count
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_res <= s1_res;
      s2_rem <= diff[RW-1:0];
    end
  end

  // final correction and output register
  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      results.status       <= s2_res.status;
      results.name_hash    <= s2_res.name_hash;
      results.name_length  <= s2_res.name_length;
      results.value_offset <= s2_res.value_offset;
      results.value_length <= s2_res.value_length;
      results.bucket       <= hlp_pkg::BUCKET_W'((s2_rem >= DIVISOR_R) ?
                                                  s2_rem - DIVISOR_R : s2_rem);
    end
  end

  assign results.valid = s3_valid;

endmodule

// File: hdl/http_header_line_parser.sv
// top level of the http header line parser
//
// usage: bytes of a header line come in on the byte channel, one request per
// byte, with line_start high on the first byte of each line. the parser checks
// the field name, hashes it in lower case, skips blanks after the colon and
// scans the value up to cr lf. at the closing lf, or at the first error, one
// result leaves on the result channel with status, name hash, bucket, name
// length, value offset and value length; bytes then count for nothing until
// the next line_start.
// throughput: one byte per clock while the result path does not hold off; the parse
// state updates once for each byte taken.
// result path: the parser registers a result on the edge that takes its closing
// byte, then the bucket modulo carries it through the reciprocal multiply, the
// remainder and the final correction in the output register.
// reset: the parser waits for a line start, the pipeline is empty.
// stall: while the receiver holds off, results queue in the four registers of
// the result path and bytes keep flowing until a result has nowhere to go.
module http_header_line_parser #(
  parameter int MAX_LINE = 4096,
  parameter int BUCKETS  = 64
) (
  input  logic          clk,
  input  logic          rst,
  hlp_byte_if.sink      bytes,
  hlp_result_if.source  results
);

  logic             core_valid;
  logic             core_ready;
  hlp_pkg::result_t core_res;

  hlp_parse #(
    .MAX_LINE (MAX_LINE)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .res_valid (core_valid),
    .res_ready (core_ready),
    .res       (core_res)
  );

  hlp_bucket #(
    .BUCKETS (BUCKETS)
  ) u_bucket (
    .clk      (clk),
    .rst      (rst),
    .in_valid (core_valid),
    .in_ready (core_ready),
    .in_res   (core_res),
    .results  (results)
  );

`ifndef SYNTH
  // an empty output means nothing in the result path can block a byte
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> bytes.ready)
    else $error("byte channel stalled with empty output");

  // bucket stays inside the table
  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (32'(results.bucket) < BUCKETS))
    else $error("bucket out of range");

  // empty name reports no name bytes and no value
  a_noname_fields: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == hlp_pkg::ST_NONAME |->
      results.name_length == '0 && results.value_length == '0)
    else $error("empty name result carries counts");
`endif

endmodule
